// ===== rtl/okvt_pkg.sv =====
package okvt_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // field widths on the ports
    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // input word layout
    localparam int CMD_LSB   = 0;
    localparam int KEY_LSB   = CMD_LSB + CMD_W;
    localparam int VAL_LSB   = KEY_LSB + KEY_W;
    localparam int POS_LSB   = VAL_LSB + VAL_W;
    localparam int S_TDATA_W = ((POS_LSB + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + KEY_W + VAL_W + COUNT_W + 7) / 8) * 8;

    // request codes
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPSERT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_POS  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RDPOS,
        S_DONE
    } t_state;

    // result word, status in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [VAL_W-1:0]    value_out;
        logic [KEY_W-1:0]    key_out;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic key_we;
        logic val_we;
    } t_mem_we;

endpackage

// ===== rtl/okvt_mem.sv =====
module okvt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int KW    = 32,
    parameter int VW    = 32
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_raddr,
    output logic [KW-1:0]    o_rkey,
    output logic [VW-1:0]    o_rval,
    input  logic [AW-1:0]    i_waddr,
    input  okvt_pkg::t_mem_we i_we,
    input  logic [KW-1:0]    i_wkey,
    input  logic [VW-1:0]    i_wval
);
    import okvt_pkg::*;

    logic [KW-1:0] r_key_mem [DEPTH];
    logic [VW-1:0] r_val_mem [DEPTH];

    // a read of an entry written in the same cycle returns the old data
    always_ff @(posedge i_clk) begin
        if (i_we.key_we) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        if (i_we.val_we) begin
            r_val_mem[i_waddr] <= i_wval;
        end
        o_rkey <= r_key_mem[i_raddr];
        o_rval <= r_val_mem[i_raddr];
    end

endmodule

// ===== rtl/okvt_ctrl.sv =====
module okvt_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5,
    parameter int KW       = 32,
    parameter int VW       = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [okvt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [KW-1:0]                 i_key,
    input  logic [VW-1:0]                 i_val,
    input  logic [okvt_pkg::POS_W-1:0]    i_pos,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output okvt_pkg::t_result             o_res,
    output logic [AW-1:0]                 o_raddr,
    input  logic [KW-1:0]                 i_rkey,
    input  logic [VW-1:0]                 i_rval,
    output logic [AW-1:0]                 o_waddr,
    output okvt_pkg::t_mem_we             o_we,
    output logic [KW-1:0]                 o_wkey,
    output logic [VW-1:0]                 o_wval
);
    import okvt_pkg::*;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_chk, n_chk;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KW-1:0]       r_key, n_key;
    logic [VW-1:0]       r_val, n_val;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [KW-1:0]       r_kout, n_kout;
    logic [VW-1:0]       r_vout, n_vout;

    logic issue;
    logic hit;
    logic full;
    logic pos_ok;
    logic in_acc;

    assign issue  = r_rd_idx < r_count;
    assign hit    = r_chk && (i_rkey == r_key);
    assign full   = r_count == CW'(CAPACITY);
    assign pos_ok = 32'(i_pos) < 32'(r_count);
    assign in_acc = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_INSERT, CMD_UPDATE, CMD_UPSERT, CMD_ERASE, CMD_LOOKUP: begin
                            n_state = S_SEARCH;
                        end
                        CMD_READ_POS: begin
                            n_state = pos_ok ? S_RDPOS : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = (r_cmd == CMD_ERASE) ? S_SHIFT : S_DONE;
                end else if (!issue) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!issue) begin
                    n_state = S_DONE;
                end
            end
            S_RDPOS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count   = r_count;
        n_chk     = r_chk;
        n_rd_idx  = r_rd_idx;
        n_chk_idx = r_chk_idx;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_status  = r_status;
        n_kout    = r_kout;
        n_vout    = r_vout;
        o_raddr   = r_rd_idx[AW-1:0];
        o_waddr   = r_chk_idx;
        o_we      = '0;
        o_wkey    = r_key;
        o_wval    = r_val;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_key    = i_key;
                    n_val    = i_val;
                    n_rd_idx = '0;
                    n_chk    = 1'b0;
                    n_status = ST_OK;
                    n_kout   = '0;
                    n_vout   = '0;
                    if (i_cmd == CMD_READ_POS) begin
                        o_raddr = AW'(i_pos);
                        if (!pos_ok) begin
                            n_status = ST_RANGE;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            n_status = ST_PRESENT;
                        end
                        CMD_UPDATE, CMD_UPSERT: begin
                            o_we.val_we = 1'b1;
                            o_waddr     = r_chk_idx;
                        end
                        CMD_ERASE: begin
                            n_rd_idx = CW'(r_chk_idx) + CW'(1);
                            n_chk    = 1'b0;
                        end
                        CMD_LOOKUP: begin
                            n_vout = i_rval;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end else if (issue) begin
                    o_raddr   = r_rd_idx[AW-1:0];
                    n_chk     = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                end else begin
                    // key absent
                    case (r_cmd)
                        CMD_INSERT, CMD_UPSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we.key_we = 1'b1;
                                o_we.val_we = 1'b1;
                                o_waddr     = r_count[AW-1:0];
                                n_count     = r_count + CW'(1);
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // move the entry read last cycle one place down
                if (r_chk) begin
                    o_we.key_we = 1'b1;
                    o_we.val_we = 1'b1;
                    o_waddr     = r_chk_idx - AW'(1);
                    o_wkey      = i_rkey;
                    o_wval      = i_rval;
                end
                if (issue) begin
                    o_raddr   = r_rd_idx[AW-1:0];
                    n_chk     = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                end else begin
                    n_chk   = 1'b0;
                    n_count = r_count - CW'(1);
                end
            end
            S_RDPOS: begin
                n_kout = i_rkey;
                n_vout = i_rval;
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;

    always_comb begin
        o_res.status      = r_status;
        o_res.key_out     = KEY_W'(r_kout);
        o_res.value_out   = VAL_W'(r_vout);
        o_res.entry_count = COUNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_val     <= n_val;
        r_status  <= n_status;
        r_kout    <= n_kout;
        r_vout    <= n_vout;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
            || r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we.key_we || o_we.val_we) |-> (r_state == S_SEARCH || r_state == S_SHIFT))
        else $error("store written outside search or shift");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("sequencer idle right after taking a word");

endmodule

// ===== rtl/ordered_key_value_table.sv =====
// channel   direction  tdata bits (lowest first)
// s_axis    in         cmd[2:0] key[34:3] value[66:35] position[70:67] zero[71]
// m_axis    out        status[2:0] key_out[34:3] value_out[66:35] entry_count_out[71:67]
//
// key requests search one entry per cycle through the single read port of the memory;
// an erase hit then moves the later entries down; each result word reaches m_axis
// through the output register once the sequencer finishes; reset clears only the entry count,
// the sequencer and the output valid flag, and the stores need no clearing pass;
// a stalled output word holds in the output register, and the sequencer keeps its result
// and takes no new word until that register is free
module ordered_key_value_table #(
    parameter int CAPACITY   = okvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cmd, key, value, position
    input  logic [okvt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // status, key_out, value_out, entry_count_out
    output logic [okvt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready
);
    import okvt_pkg::*;

    // keys and values above 32 bits never see more than the 32 port bits
    localparam int KS = (KEY_BITS > KEY_W) ? KEY_W : KEY_BITS;
    localparam int VS = (VALUE_BITS > VAL_W) ? VAL_W : VALUE_BITS;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // word fields
    logic [CMD_W-1:0] in_cmd;
    logic [KS-1:0]    in_key;
    logic [VS-1:0]    in_val;
    logic [POS_W-1:0] in_pos;

    assign in_cmd = s_axis_tdata[CMD_LSB +: CMD_W];
    assign in_key = s_axis_tdata[KEY_LSB +: KS];
    assign in_val = s_axis_tdata[VAL_LSB +: VS];
    assign in_pos = s_axis_tdata[POS_LSB +: POS_W];

    // sequencer to memory
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [KS-1:0] rkey;
    logic [VS-1:0] rval;
    logic [KS-1:0] wkey;
    logic [VS-1:0] wval;
    t_mem_we       we;

    // sequencer to output register
    t_result res;
    logic    res_valid;
    logic    out_free;

    logic    r_out_valid;
    t_result r_out;

    okvt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .KW    (KS),
        .VW    (VS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_raddr (raddr),
        .o_rkey  (rkey),
        .o_rval  (rval),
        .i_waddr (waddr),
        .i_we    (we),
        .i_wkey  (wkey),
        .i_wval  (wval)
    );

    okvt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW),
        .KW       (KS),
        .VW       (VS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (in_cmd),
        .i_key       (in_key),
        .i_val       (in_val),
        .i_pos       (in_pos),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res),
        .o_raddr     (raddr),
        .i_rkey      (rkey),
        .i_rval      (rval),
        .o_waddr     (waddr),
        .o_we        (we),
        .o_wkey      (wkey),
        .o_wval      (wval)
    );

    // output register: takes a result when empty or when its word leaves this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

endmodule
